>>> rtl/core/sld_pkg.sv
package sld_pkg;

    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned THRESH_W    = 31;
    localparam int unsigned SUM_W       = 64;
    localparam int unsigned SQUARE_W    = 63;
    localparam int unsigned FAST_SHIFT  = 7;
    localparam int unsigned GAIN_SHIFT  = 5;
    localparam int unsigned SUM_SHIFT   = 3;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned X_W         = SQUARE_W - FAST_SHIFT;

    localparam logic [GAIN_W-1:0]   FAST_GAIN      = 16'd33550;
    localparam logic [THRESH_W-1:0] THRESH_DEFAULT = 31'h7FFF_FFFF;

    // Magnitude of a 32-bit two's complement word as unsigned; -2^31 gives 2^31.
    function automatic logic [SAMPLE_W-1:0] mag32(input logic [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? (SAMPLE_W'(0) - v) : v;
    endfunction

endpackage

>>> rtl/core/sld_fast_weight.sv
module sld_fast_weight
    import sld_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic [X_W-1:0]      x_in,
    output logic [SAMPLE_W-1:0] level_out
);

    localparam int unsigned PROD_W = SAMPLE_W + GAIN_W;

    logic [SUM_W-1:0]    delay_reg, delay_next;
    logic [SUM_W-1:0]    wout_reg, wout_next;
    logic [SAMPLE_W-1:0] hi_word;
    logic [SAMPLE_W-1:0] hi_mag;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    gain_mag;
    logic [SUM_W-1:0]    gain;
    logic [SUM_W-1:0]    x_ext;

    // Feedback gain from the signed high word of the previous output.
    always_comb begin
        hi_word    = wout_reg[SUM_W-1 -: SAMPLE_W];
        hi_mag     = mag32(hi_word);
        prod       = {{GAIN_W{1'b0}}, hi_mag} * {{SAMPLE_W{1'b0}}, FAST_GAIN};
        gain_mag   = SUM_W'({prod, {GAIN_SHIFT{1'b0}}});
        gain       = hi_word[SAMPLE_W-1] ? (SUM_W'(0) - gain_mag) : gain_mag;
        x_ext      = SUM_W'(x_in);
        wout_next  = x_ext + delay_reg;
        delay_next = x_ext + (wout_reg - gain);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            wout_reg  <= '0;
        end else if (step_en) begin
            delay_reg <= delay_next;
            wout_reg  <= wout_next;
        end
    end

    assign level_out = wout_reg[SUM_W-1 -: SAMPLE_W];

endmodule

>>> rtl/core/sound_level_detector_backend.sv
// Sound level meter back end with fast time weighting. Each input item carries
// the raw converter sample and the C- and A-weighted filter outputs of one
// sample, plus two flags; each item yields exactly one result item holding the
// overload count, the held C-weighted peak, the 64-bit sum of 8*A^2 with its
// wrap count, and the high word of the fast time-weighted mean square. The
// block takes one item per clock cycle while results are taken and passes
// each item through the input register, the magnitude and square register
// and the result register in turn. Full rate is possible because the
// time-weighting feedback loop, a 32x16 multiply feeding two 64-bit adds,
// is combinational between its registers. The state registers and valid
// flags clear on reset; there is no clearing pass.
// The overload threshold may only be written while no item is in flight.
module sound_level_detector_backend
    import sld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration: overload threshold
    input  logic                  cfg_wr_en,
    input  logic [THRESH_W-1:0]   cfg_wr_data,

    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] adc_sample, [63:32] c_weighted, [95:64] a_weighted
    input  logic [95:0]           s_tdata,
    // [0] catch_peak, [1] clear_sum
    input  logic [1:0]            s_tuser,

    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] overload_count, [63:32] peak_held, [127:64] square_sum,
    // [159:128] sum_wraps, [191:160] fast_level
    output logic [191:0]          m_tdata
);

    // ------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or its item moves on,
    // so a stalled result does not stop items filling the earlier stages.
    // ------------------------------------------------------------------
    logic p1_valid_reg, p1_valid_next;
    logic p2_valid_reg, p2_valid_next;
    logic m_valid_reg,  m_valid_next;
    logic out_ready, p2_ready, p1_ready;
    logic p1_load, p2_load, out_load;

    always_comb begin
        out_ready     = !m_valid_reg || m_tready;
        p2_ready      = !p2_valid_reg || out_ready;
        p1_ready      = !p1_valid_reg || p2_ready;
        p1_load       = s_tvalid && p1_ready;
        p2_load       = p1_valid_reg && p2_ready;
        out_load      = p2_valid_reg && out_ready;
        p1_valid_next = p1_ready  ? s_tvalid     : p1_valid_reg;
        p2_valid_next = p2_ready  ? p1_valid_reg : p2_valid_reg;
        m_valid_next  = out_ready ? p2_valid_reg : m_valid_reg;
    end

    assign s_tready = p1_ready;
    assign m_tvalid = m_valid_reg;

    // ------------------------------------------------------------------
    // Threshold register
    // ------------------------------------------------------------------
    logic [THRESH_W-1:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_DEFAULT;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] p1_adc_reg, p1_c_reg, p1_a_reg;
    logic                p1_catch_reg, p1_clear_reg;

    always_ff @(posedge aclk) begin
        if (p1_load) begin
            p1_adc_reg   <= s_tdata[SAMPLE_W-1:0];
            p1_c_reg     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            p1_a_reg     <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            p1_catch_reg <= s_tuser[0];
            p1_clear_reg <= s_tuser[1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes, overload compare and the A-weighted square.
    // None of this depends on the stage 3 state, so it runs ahead of the update.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] adc_mag, a_mag;
    logic [SQUARE_W-1:0] a_sq_full;
    logic                p2_ovl_reg;
    logic [SAMPLE_W-1:0] p2_cmag_reg;
    logic [SQUARE_W-1:0] p2_square_reg;
    logic                p2_catch_reg, p2_clear_reg;

    always_comb begin
        adc_mag   = mag32(p1_adc_reg);
        a_mag     = mag32(p1_a_reg);
        // at most 2^62, so 63 bits hold it
        a_sq_full = SQUARE_W'({32'b0, a_mag} * {32'b0, a_mag});
    end

    always_ff @(posedge aclk) begin
        if (p2_load) begin
            p2_ovl_reg    <= adc_mag > {1'b0, thresh_reg};
            p2_cmag_reg   <= mag32(p1_c_reg);
            p2_square_reg <= a_sq_full;
            p2_catch_reg  <= p1_catch_reg;
            p2_clear_reg  <= p1_clear_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: state update. The state registers are the result register:
    // they change only when a result is loaded and hold while it waits.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ovl_cnt_reg,   ovl_cnt_next;
    logic [SAMPLE_W-1:0] peak_run_reg,  peak_run_next;
    logic [SAMPLE_W-1:0] peak_held_reg, peak_held_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [SAMPLE_W-1:0] wraps_reg,     wraps_next;
    logic [SAMPLE_W-1:0] peak_max;
    logic [SUM_W-1:0]    sum_base;
    logic [SAMPLE_W-1:0] wraps_base;
    logic [SUM_W-1:0]    addend;
    logic                wrapped;
    logic [SAMPLE_W-1:0] fast_level;

    always_comb begin
        ovl_cnt_next = ovl_cnt_reg + SAMPLE_W'(p2_ovl_reg);

        peak_max = (p2_cmag_reg > peak_run_reg) ? p2_cmag_reg : peak_run_reg;
        if (p2_catch_reg) begin
            peak_held_next = peak_max;
            peak_run_next  = '0;
        end else begin
            peak_held_next = peak_held_reg;
            peak_run_next  = peak_max;
        end

        // clear_sum acts before this sample is added
        sum_base   = p2_clear_reg ? '0 : sum_reg;
        wraps_base = p2_clear_reg ? '0 : wraps_reg;
        addend     = SUM_W'({p2_square_reg, {SUM_SHIFT{1'b0}}});
        sum_next   = sum_base + addend;
        // a wrap is seen only as a drop of the high word
        wrapped    = sum_base[SUM_W-1 -: SAMPLE_W] > sum_next[SUM_W-1 -: SAMPLE_W];
        wraps_next = wraps_base + SAMPLE_W'(wrapped);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_cnt_reg   <= '0;
            peak_run_reg  <= '0;
            peak_held_reg <= '0;
            sum_reg       <= '0;
            wraps_reg     <= '0;
        end else if (out_load) begin
            ovl_cnt_reg   <= ovl_cnt_next;
            peak_run_reg  <= peak_run_next;
            peak_held_reg <= peak_held_next;
            sum_reg       <= sum_next;
            wraps_reg     <= wraps_next;
        end
    end

    sld_fast_weight u_fast_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (out_load),
        .x_in      (p2_square_reg[SQUARE_W-1:FAST_SHIFT]),
        .level_out (fast_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tdata = {fast_level, wraps_reg, sum_reg, peak_held_reg, ovl_cnt_reg};

endmodule
